// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge, reset included.
`define U2C_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Checked only outside reset.
`define U2C_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== rtl/u2c_pkg.sv =====
// Shared types, constants and lead byte decode for the UTF-8 to cp1252 converter.
// No dependencies.
package u2c_pkg;

  localparam int unsigned U2C_QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } u2c_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       text_done;
  } u2c_out_t;

  // A finished run: bytes to decode, lead first, and how many are valid
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
    logic            eot;
  } u2c_job_t;

  typedef struct packed {
    logic     push;
    u2c_job_t job;
  } u2c_qwr_t;

  typedef struct packed {
    logic     valid;
    u2c_job_t job;
  } u2c_qrd_t;

  // Sequence length announced by a lead byte; 0 when it is no lead
  function automatic logic [2:0] lead_len(input logic [7:0] c);
    logic [2:0] len;
    begin
      if (!c[7])                    len = 3'd1;
      else if (c[7:5] == 3'b110)    len = 3'd2;
      else if (c[7:4] == 4'b1110)   len = 3'd3;
      else if (c[7:3] == 5'b11110)  len = 3'd4;
      else                          len = 3'd0;
      return len;
    end
  endfunction

endpackage

// ===== rtl/utf8_to_cp1252_converter_unit.sv =====
// UTF-8 to Windows-1252 converter. Takes one UTF-8 byte per cycle (push/full)
// and delivers cp1252 words through a queue-style output (empty/pop). A byte that
// completes a sequence yields its word via the queue; a byte that ends the text
// in mid-sequence flushes up to three words, one per cycle, from the back decoder.
// The run queue (QUEUE_DEPTH runs) lets the input keep streaming during such a
// flush; full rises only when the queue fills. Sustained rate is one byte per cycle
// as long as each byte yields at most one word and the consumer pops every cycle.
// Depends on u2c_pkg, u2c_front, u2c_fifo and u2c_back.
module utf8_to_cp1252_converter_unit #(
  parameter int unsigned QUEUE_DEPTH = u2c_pkg::U2C_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  u2c_pkg::u2c_in_t  in_data,
  output logic              empty,
  input  logic              pop,
  output u2c_pkg::u2c_out_t out_data
);
  import u2c_pkg::*;

  u2c_qwr_t qwr;
  u2c_qrd_t qrd;
  logic     rd_pop;
  logic     accept;

  assign accept = push && !full;

  u2c_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_word (in_data),
    .qwr     (qwr)
  );

  u2c_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .qwr    (qwr),
    .rd_pop (rd_pop),
    .qrd    (qrd),
    .full   (full)
  );

  u2c_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .qrd      (qrd),
    .rd_pop   (rd_pop),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

endmodule

// ===== rtl/u2c_front.sv =====
// Front part: gathers the bytes of one UTF-8 sequence and queues the finished run.
// Depends on u2c_pkg.
module u2c_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  u2c_pkg::u2c_in_t in_word,
  output u2c_pkg::u2c_qwr_t qwr
);
  import u2c_pkg::*;

  logic [2:0][7:0] held_r;
  logic [1:0]      held_cnt_r, held_cnt_nxt;
  logic [2:0]      need_r, need_nxt;

  logic [2:0] n;
  logic [2:0] need;
  logic [2:0] len;
  logic       complete;

  always_comb begin
    len      = lead_len(in_word.in_byte);
    n        = {1'b0, held_cnt_r} + 3'd1;
    need     = (held_cnt_r == 2'd0) ? ((len == 3'd0) ? 3'd1 : len) : need_r;
    complete = in_word.end_of_text || (n >= need);

    qwr.push      = accept && complete;
    qwr.job.count = n;
    qwr.job.eot   = in_word.end_of_text;
    for (int i = 0; i < 3; i++) begin
      qwr.job.bytes[i] = (2'(i) < held_cnt_r) ? held_r[i] : in_word.in_byte;
    end
    qwr.job.bytes[3] = in_word.in_byte;

    held_cnt_nxt = held_cnt_r;
    need_nxt     = need_r;
    if (accept) begin
      if (complete) begin
        held_cnt_nxt = 2'd0;
        need_nxt     = 3'd1;
      end else begin
        held_cnt_nxt = n[1:0];
        need_nxt     = need;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= 2'd0;
      need_r     <= 3'd1;
    end else begin
      held_cnt_r <= held_cnt_nxt;
      need_r     <= need_nxt;
    end
  end

  // hold the byte of an unfinished sequence
  always_ff @(posedge clk) begin
    if (accept && !complete) begin
      case (held_cnt_r)
        2'd0:    held_r[0] <= in_word.in_byte;
        2'd1:    held_r[1] <= in_word.in_byte;
        default: held_r[2] <= in_word.in_byte;
      endcase
    end
  end

endmodule

// ===== rtl/u2c_fifo.sv =====
// Short run queue between the front and back parts.
// Depends on u2c_pkg.
module u2c_fifo #(
  parameter int unsigned DEPTH = u2c_pkg::U2C_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  u2c_pkg::u2c_qwr_t qwr,
  input  logic              rd_pop,
  output u2c_pkg::u2c_qrd_t qrd,
  output logic              full
);
  import u2c_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  u2c_job_t         slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  always_comb begin
    full      = (cnt_r == CNT_W'(DEPTH));
    qrd.valid = (cnt_r != '0);
    qrd.job   = slot_r[rd_ptr_r];
    do_wr     = qwr.push && !full;
    do_rd     = rd_pop && qrd.valid;

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_wr) wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_rd) rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

    cnt_nxt = cnt_r;
    if (do_wr && !do_rd)      cnt_nxt = cnt_r + 1'b1;
    else if (do_rd && !do_wr) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slot_r[wr_ptr_r] <= qwr.job;
  end

endmodule

// ===== rtl/u2c_back.sv =====
// Back part: walks the queue head run, one cp1252 word per cycle unless stalled.
// Depends on u2c_pkg.
module u2c_back (
  input  logic              clk,
  input  logic              rst_n,
  input  u2c_pkg::u2c_qrd_t qrd,
  output logic              rd_pop,
  input  logic              pop,
  output logic              empty,
  output u2c_pkg::u2c_out_t out_data
);
  import u2c_pkg::*;

  localparam logic [7:0] QMARK = 8'h3F;

  function automatic logic [7:0] map_cp(input logic [20:0] cp);
    logic [7:0] r;
    begin
      if (cp inside {[21'h00 : 21'h7F], [21'hA0 : 21'hFF]}) begin
        r = cp[7:0];
      end else begin
        case (cp)
          21'h20AC: r = 8'h80;
          21'h201A: r = 8'h82;
          21'h0192: r = 8'h83;
          21'h201E: r = 8'h84;
          21'h2026: r = 8'h85;
          21'h2020: r = 8'h86;
          21'h2021: r = 8'h87;
          21'h02C6: r = 8'h88;
          21'h2030: r = 8'h89;
          21'h0160: r = 8'h8A;
          21'h2039: r = 8'h8B;
          21'h0152: r = 8'h8C;
          21'h017D: r = 8'h8E;
          21'h2018: r = 8'h91;
          21'h2019: r = 8'h92;
          21'h201C: r = 8'h93;
          21'h201D: r = 8'h94;
          21'h2022: r = 8'h95;
          21'h2013: r = 8'h96;
          21'h2014: r = 8'h97;
          21'h02DC: r = 8'h98;
          21'h2122: r = 8'h99;
          21'h0161: r = 8'h9A;
          21'h203A: r = 8'h9B;
          21'h0153: r = 8'h9C;
          21'h017E: r = 8'h9E;
          21'h0178: r = 8'h9F;
          default:  r = QMARK;
        endcase
      end
      return r;
    end
  endfunction

  logic [1:0] pos_r, pos_nxt;
  logic [1:0] k_r, k_nxt;
  logic       vld_r, vld_nxt;
  u2c_out_t   out_r, out_nxt;

  logic [7:0]  c, b1, b2, b3;
  logic [2:0]  len;
  logic [3:0]  span;
  logic        whole;
  logic [20:0] cp;
  logic [2:0]  adv;
  logic [2:0]  next_pos;
  logic        done;
  logic        load;

  always_comb begin
    c    = qrd.job.bytes[pos_r];
    b1   = qrd.job.bytes[pos_r + 2'd1];
    b2   = qrd.job.bytes[pos_r + 2'd2];
    b3   = qrd.job.bytes[pos_r + 2'd3];
    len  = lead_len(c);
    span = {2'b00, pos_r} + {1'b0, len};
    whole = (len >= 3'd2) && (span <= {1'b0, qrd.job.count});

    adv = 3'd1;
    if (!c[7]) begin
      cp = {13'd0, c};
    end else if (whole) begin
      adv = len;
      case (len)
        3'd2:    cp = {10'd0, c[4:0], b1[5:0]};
        3'd3:    cp = {5'd0, c[3:0], b1[5:0], b2[5:0]};
        default: cp = {c[2:0], b1[5:0], b2[5:0], b3[5:0]};
      endcase
    end else begin
      cp = {13'd0, QMARK};
    end

    next_pos = {1'b0, pos_r} + adv;
    done     = (next_pos >= qrd.job.count) || (k_r == 2'd2);
    load     = qrd.valid && (!vld_r || pop);
    rd_pop   = load && done;

    out_nxt             = out_r;
    out_nxt.out_byte    = map_cp(cp);
    out_nxt.last_of_run = done;
    out_nxt.text_done   = qrd.job.eot;

    pos_nxt = pos_r;
    k_nxt   = k_r;
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
      pos_nxt = done ? 2'd0 : next_pos[1:0];
      k_nxt   = done ? 2'd0 : k_r + 2'd1;
    end else if (pop) begin
      vld_nxt = 1'b0;
    end

    empty    = !vld_r;
    out_data = out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 2'd0;
      k_r   <= 2'd0;
      vld_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      k_r   <= k_nxt;
      vld_r <= vld_nxt;
    end
  end

  // result word register; hold while the consumer stalls
  always_ff @(posedge clk) begin
    if (load) out_r <= out_nxt;
  end

endmodule

// ===== rtl/u2c_checker.sv =====
// Port-level checks for the converter, bound to the top level.
// Depends on u2c_pkg and assert_macros.svh.
`include "assert_macros.svh"

module u2c_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              push,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input u2c_pkg::u2c_out_t out_data
);
  import u2c_pkg::*;

  `U2C_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (empty && !full), "not idle after reset")

  `U2C_ASSERT_RUN(a_stall_hold, (!empty && !pop) |=> (!empty && $stable(out_data)), "stalled word changed")

  `U2C_ASSERT_RUN(a_full_after_push, $rose(full) |-> $past(push), "full rose without a push")

  `U2C_ASSERT_RUN(a_run_continues, (!empty && pop && !out_data.last_of_run) |=> !empty, "run broken before its last word")

endmodule

bind utf8_to_cp1252_converter_unit u2c_checker u_u2c_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);
